[rtl/vertex_rotate_scale_project_defines.svh]
// assertion macros shared by the rtl
`ifndef VERTEX_ROTATE_SCALE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_SCALE_PROJECT_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define VRSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vrsp assertion failed");
// checked during reset as well
`define VRSP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vrsp reset assertion failed");
`else
`define VRSP_ASSERT(lbl, prop)
`define VRSP_ASSERT_RST(lbl, prop)
`endif

`endif

[rtl/vrsp_pkg.sv]
package vrsp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int TRIG_W          = 16;
  localparam int SCALE_W         = 16;
  localparam int OFFSET_W        = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  // Q1.14 trig words, Q4.12 scale: three rotations and the scale give 54 fraction bits
  localparam int Q14        = 14;
  localparam int FRAC_TOTAL = 3 * Q14 + 12;
  localparam int RND_BIT    = FRAC_TOTAL - 1;

  localparam logic [CFG_DATA_W-1:0] ROT_RESET    = 32'h0000_4000;
  localparam logic [SCALE_W-1:0]    SCALE_RESET  = 16'h1000;
  localparam logic [OFFSET_W-1:0]   OFFSET_RESET = 16'h0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X,
    REG_ROT_Y,
    REG_ROT_Z,
    REG_SCALE,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z
  } cfg_reg_t;

endpackage

[rtl/vertex_rotate_scale_project.sv]
// Vertex transform: rotate about Z, then X, then Y, scale, round, saturate, offset,
// and an oblique projection of the result.
// Input channel: in_valid/in_ready carry vert_x, vert_y, vert_z, one vertex per word.
// Output channel: out_valid/out_ready carry out_x, out_y, out_z, proj_x, proj_y.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0..6 selects
// rot_x, rot_y, rot_z (sine in bits 31:16, cosine in 15:0, Q1.14), scale (Q4.12),
// offset_x, offset_y, offset_z. Other indexes are ignored. cfg_ready is always high;
// write only while no vertex is in flight.
// Pipeline: 9 register stages. Throughput: one vertex per cycle while the output is not
// stalled, set by the nine-stage multiply pipeline (one rotation's products, then its
// sums, per pair of stages, then the scale multiply, the rounding stage and the output
// register).
// Reset: all stage valids clear, rotations go to identity, scale to 1.0, offsets to 0.
// Stall: when out_ready is low the output register holds; earlier stages keep moving
// until they meet an occupied stage, so bubbles close up and in_ready drops only
// when every stage holds a vertex.
`include "vertex_rotate_scale_project_defines.svh"

module vertex_rotate_scale_project
  import vrsp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] vert_x,
  input  logic signed [COORD_WIDTH-1:0] vert_y,
  input  logic signed [COORD_WIDTH-1:0] vert_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic signed [COORD_WIDTH-1:0] proj_x,
  output logic signed [COORD_WIDTH-1:0] proj_y
);

  localparam int W      = COORD_WIDTH;
  localparam int NSTAGE = 9;
  localparam int W1     = W + TRIG_W;         // coordinate times trig
  localparam int W2     = W + TRIG_W + 1;     // after rotation about z
  localparam int W3     = W2 + TRIG_W;        // rotated value times trig
  localparam int W4     = W3 + 1;             // after rotation about x
  localparam int W5     = W4 + TRIG_W;
  localparam int W6     = W5 + 1;             // after rotation about y
  localparam int W7     = W6 + SCALE_W + 1;   // after scaling
  localparam int QW     = W7 - FRAC_TOTAL;
  localparam int OW     = (W > OFFSET_W) ? W : OFFSET_W;

  // configuration registers
  logic [CFG_DATA_W-1:0]      rot_x, rot_y, rot_z;
  logic [SCALE_W-1:0]         scale;
  logic signed [OFFSET_W-1:0] offset_x, offset_y, offset_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_x    <= ROT_RESET;
      rot_y    <= ROT_RESET;
      rot_z    <= ROT_RESET;
      scale    <= SCALE_RESET;
      offset_x <= OFFSET_RESET;
      offset_y <= OFFSET_RESET;
      offset_z <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROT_X:    rot_x    <= cfg_data;
        REG_ROT_Y:    rot_y    <= cfg_data;
        REG_ROT_Z:    rot_z    <= cfg_data;
        REG_SCALE:    scale    <= cfg_data[SCALE_W-1:0];
        REG_OFFSET_X: offset_x <= cfg_data[OFFSET_W-1:0];
        REG_OFFSET_Y: offset_y <= cfg_data[OFFSET_W-1:0];
        REG_OFFSET_Z: offset_z <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [TRIG_W-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
  logic signed [SCALE_W:0]  scale_s;

  assign sin_x   = rot_x[CFG_DATA_W-1:TRIG_W];
  assign cos_x   = rot_x[TRIG_W-1:0];
  assign sin_y   = rot_y[CFG_DATA_W-1:TRIG_W];
  assign cos_y   = rot_y[TRIG_W-1:0];
  assign sin_z   = rot_z[CFG_DATA_W-1:TRIG_W];
  assign cos_z   = rot_z[TRIG_W-1:0];
  assign scale_s = $signed({1'b0, scale});

  // stage valids and per-stage advance
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 0: products for rotation about z
  logic signed [W1-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [W-1:0]  z0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_xc <= W1'(vert_x) * W1'(cos_z);
      p_ys <= W1'(vert_y) * W1'(sin_z);
      p_xs <= W1'(vert_x) * W1'(sin_z);
      p_yc <= W1'(vert_y) * W1'(cos_z);
      z0   <= vert_z;
    end
  end

  // stage 1: rotation about z, Q14
  logic signed [W2-1:0] x1, y1;
  logic signed [W-1:0]  z1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1 <= W2'(p_xc) + W2'(p_ys);
      y1 <= W2'(p_yc) - W2'(p_xs);
      z1 <= z0;
    end
  end

  // stage 2: products for rotation about x
  logic signed [W3-1:0] a_yc, a_ys;
  logic signed [W1-1:0] b_zs, b_zc;
  logic signed [W2-1:0] x1_2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a_yc <= W3'(y1) * W3'(cos_x);
      a_ys <= W3'(y1) * W3'(sin_x);
      b_zs <= W1'(z1) * W1'(sin_x);
      b_zc <= W1'(z1) * W1'(cos_x);
      x1_2 <= x1;
    end
  end

  // stage 3: rotation about x, Q28 (z enters as z << 14)
  logic signed [W4-1:0] y2, z2;
  logic signed [W2-1:0] x1_3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      y2   <= W4'(a_yc) + (W4'(b_zs) <<< Q14);
      z2   <= (W4'(b_zc) <<< Q14) - W4'(a_ys);
      x1_3 <= x1_2;
    end
  end

  // stage 4: products for rotation about y
  logic signed [W3-1:0] e_xc, e_xs;
  logic signed [W5-1:0] f_zs, f_zc;
  logic signed [W4-1:0] y2_4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      e_xc <= W3'(x1_3) * W3'(cos_y);
      e_xs <= W3'(x1_3) * W3'(sin_y);
      f_zs <= W5'(z2) * W5'(sin_y);
      f_zc <= W5'(z2) * W5'(cos_y);
      y2_4 <= y2;
    end
  end

  // stage 5: rotation about y, Q42
  logic signed [W6-1:0] x3, y3, z3;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      x3 <= (W6'(e_xc) <<< Q14) - W6'(f_zs);
      z3 <= (W6'(e_xs) <<< Q14) + W6'(f_zc);
      y3 <= W6'(y2_4) <<< Q14;
    end
  end

  // stage 6: scale, Q54
  logic signed [W7-1:0] m_x, m_y, m_z;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      m_x <= W7'(x3) * W7'(scale_s);
      m_y <= W7'(y3) * W7'(scale_s);
      m_z <= W7'(z3) * W7'(scale_s);
    end
  end

  // half away from zero: floor((p + half - neg) / 2^54), then clamp
  function automatic logic signed [W-1:0] round_sat(input logic signed [W7-1:0] p);
    logic signed [W7-1:0] rnd;
    logic [QW-1:0]        q;
    rnd = p + (W7'(1) <<< RND_BIT) - W7'(p[W7-1]);
    q   = rnd[W7-1:FRAC_TOTAL];
    if (q[QW-1:W-1] == '0 || q[QW-1:W-1] == '1) begin
      return q[W-1:0];
    end else if (q[QW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // stage 7: rounded and saturated coordinates
  logic signed [W-1:0] r_x, r_y, r_z;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      r_x <= round_sat(m_x);
      r_y <= round_sat(m_y);
      r_z <= round_sat(m_z);
    end
  end

  // stage 8: offsets wrap to the coordinate width, then the projection
  logic signed [OW-1:0] offx_e, offy_e, offz_e;
  logic signed [W-1:0]  ox, oy, oz, oz_half;

  assign offx_e  = OW'(offset_x);
  assign offy_e  = OW'(offset_y);
  assign offz_e  = OW'(offset_z);
  assign ox      = r_x + offx_e[W-1:0];
  assign oy      = r_y + offy_e[W-1:0];
  assign oz      = r_z + offz_e[W-1:0];
  // halve toward zero
  assign oz_half = $signed(oz + W'(oz[W-1])) >>> 1;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      out_x  <= ox;
      out_y  <= oy;
      out_z  <= oz;
      proj_x <= ox + oz_half;
      proj_y <= oy - oz_half;
    end
  end

  `VRSP_ASSERT(a_empty_out_takes_input, !v[NSTAGE-1] |-> in_ready)
  `VRSP_ASSERT(a_accept_fills_first_stage, in_valid && in_ready |=> v[0])
  `VRSP_ASSERT_RST(a_reset_clears_valids, $past(rst) |-> v == '0)

endmodule

[verif/vertex_rotate_scale_project_tb.sv]
module vertex_rotate_scale_project_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vrsp_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_SETTINGS = 14;
  localparam int VERTS_PER_SETTING = 125;
  // index past the register list, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic signed [127:0] wide_t;
  localparam wide_t UNIT_Q14 = 128'sd16384;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } projected_vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] vert_x = '0;
  logic signed [CW-1:0] vert_y = '0;
  logic signed [CW-1:0] vert_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic signed [CW-1:0] proj_x;
  logic signed [CW-1:0] proj_y;

  // shadow of the register file used for prediction
  logic [CFG_DATA_W-1:0] rot_x_cfg = ROT_RESET;
  logic [CFG_DATA_W-1:0] rot_y_cfg = ROT_RESET;
  logic [CFG_DATA_W-1:0] rot_z_cfg = ROT_RESET;
  logic [SCALE_W-1:0] gain_q12 = SCALE_RESET;
  logic [OFFSET_W-1:0] off_x = OFFSET_RESET;
  logic [OFFSET_W-1:0] off_y = OFFSET_RESET;
  logic [OFFSET_W-1:0] off_z = OFFSET_RESET;

  vertex_t pending_vertices[$];
  projected_vertex_t transformed_q[$];
  vertex_t next_vertex;
  projected_vertex_t want;

  int errors = 0;
  int vertices_queued = 0;
  int vertices_accepted = 0;
  int results_checked = 0;
  int settings_used = 1;
  int idle_left = 0;
  int stall_left = 0;
  logic drive_valid;
  bit in_gapless = 1'b0;
  bit out_gapless = 1'b0;

  vertex_rotate_scale_project #(.COORD_WIDTH(CW)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .vert_x(vert_x),
    .vert_y(vert_y),
    .vert_z(vert_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .proj_x(proj_x),
    .proj_y(proj_y)
  );

  always #6 clk = ~clk;

  // scale the exact q42 value, round half away from zero, clamp to the coordinate range
  function automatic logic signed [CW-1:0] round_saturate(wide_t v);
    logic [127:0] mag;
    logic neg;
    neg = v[127];
    mag = neg ? 128'(-v) : 128'(v);
    mag = (mag * gain_q12 + (128'd1 << RND_BIT)) >> FRAC_TOTAL;
    if (neg) begin
      if (mag > (128'd1 << (CW - 1))) mag = 128'd1 << (CW - 1);
      return -mag[CW-1:0];
    end
    if (mag > (128'd1 << (CW - 1)) - 1) mag = (128'd1 << (CW - 1)) - 1;
    return mag[CW-1:0];
  endfunction

  function automatic projected_vertex_t transform_vertex(vertex_t v);
    wide_t vx, vy, vz, sx, cx, sy, cy, sz, cz;
    wide_t x1, y1, zq, y2, z2, xq, x3, y3, z3;
    logic signed [CW-1:0] half_z;
    projected_vertex_t r;
    vx = v.x;
    vy = v.y;
    vz = v.z;
    sx = $signed(rot_x_cfg[31:16]);
    cx = $signed(rot_x_cfg[15:0]);
    sy = $signed(rot_y_cfg[31:16]);
    cy = $signed(rot_y_cfg[15:0]);
    sz = $signed(rot_z_cfg[31:16]);
    cz = $signed(rot_z_cfg[15:0]);
    // z, then x, then y; each stage keeps the full product
    x1 = vx * cz + vy * sz;
    y1 = vy * cz - vx * sz;
    zq = vz * UNIT_Q14;
    y2 = y1 * cx + zq * sx;
    z2 = zq * cx - y1 * sx;
    xq = x1 * UNIT_Q14;
    x3 = xq * cy - z2 * sy;
    z3 = xq * sy + z2 * cy;
    y3 = y2 * UNIT_Q14;
    r.x = round_saturate(x3) + $signed(off_x);
    r.y = round_saturate(y3) + $signed(off_y);
    r.z = round_saturate(z3) + $signed(off_z);
    half_z = r.z / 2;
    r.px = r.x + half_z;
    r.py = r.y - half_z;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] edge_coord();
    case ($urandom_range(0, 8))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h0001;
      5: return 16'h7FFF;
      6: return 16'h4000;
      7: return 16'hC000;
      default: return 16'h7FFE;
    endcase
  endfunction

  function automatic logic [15:0] random_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom());
    if (r < 8) return 16'($urandom_range(0, 4095) - 2048);
    return edge_coord();
  endfunction

  // sine in the upper half, cosine in the lower
  function automatic logic [31:0] trig_word(int mode);
    real theta;
    int s, c;
    case (mode)
      1: return $urandom();
      2: return {edge_coord(), edge_coord()};
      default: begin
        theta = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        s = $rtoi($sin(theta) * 16383.0);
        c = $rtoi($cos(theta) * 16383.0);
        return {s[15:0], c[15:0]};
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROT_X: rot_x_cfg = data;
      REG_ROT_Y: rot_y_cfg = data;
      REG_ROT_Z: rot_z_cfg = data;
      REG_SCALE: gain_q12 = data[15:0];
      REG_OFFSET_X: off_x = data[15:0];
      REG_OFFSET_Y: off_y = data[15:0];
      REG_OFFSET_Z: off_z = data[15:0];
      default: ;
    endcase
  endtask

  task automatic add_vertex(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    pending_vertices.push_back(v);
    vertices_queued++;
  endtask

  // every vertex accepted and every result back, then let the pipeline settle
  task automatic wait_drained();
    while (vertices_accepted != vertices_queued || transformed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // vertex driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      drive_valid = in_valid;
      if (in_valid && in_ready) begin
        next_vertex.x = vert_x;
        next_vertex.y = vert_y;
        next_vertex.z = vert_z;
        transformed_q.push_back(transform_vertex(next_vertex));
        vertices_accepted++;
        drive_valid = 1'b0;
        idle_left = in_gapless ? 0 : pick_gap();
      end
      if (!drive_valid) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_vertices.size() != 0) begin
          next_vertex = pending_vertices.pop_front();
          vert_x <= next_vertex.x;
          vert_y <= next_vertex.y;
          vert_z <= next_vertex.z;
          drive_valid = 1'b1;
        end
      end
      in_valid <= drive_valid;
    end
  end

  task automatic check_coord(input string name, input logic signed [CW-1:0] exp_v,
                             input logic signed [CW-1:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (transformed_q.size() == 0) begin
          $error("result word with no vertex outstanding");
          errors++;
        end else begin
          want = transformed_q.pop_front();
          check_coord("out_x", want.x, out_x);
          check_coord("out_y", want.y, out_y);
          check_coord("out_z", want.z, out_z);
          check_coord("proj_x", want.px, proj_x);
          check_coord("proj_y", want.py, proj_y);
          results_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_gapless && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int mode;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity transform: coordinates pass straight through, projection wraps
    add_vertex(16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_vertex(16'h8000, 16'h8000, 16'h8000);
    add_vertex(16'h7FFF, 16'h8000, 16'h0001);
    add_vertex(16'hFFFF, 16'hFFFD, 16'hFFFF);
    add_vertex(16'hFFFD, 16'h0005, 16'h8001);
    wait_drained();

    // trig words at -2 and just under 2, full gain, offsets that wrap
    write_reg(REG_ROT_X, 32'h8000_7FFF);
    write_reg(REG_ROT_Y, 32'h7FFF_8000);
    write_reg(REG_ROT_Z, 32'h2D41_2D41);
    write_reg(REG_SCALE, 32'hABCD_FFFF);
    write_reg(REG_OFFSET_X, 32'h0000_7FFF);
    write_reg(REG_OFFSET_Y, 32'hFFFF_8000);
    write_reg(REG_OFFSET_Z, 32'h1234_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    settings_used++;
    add_vertex(16'h0001, 16'h0001, 16'h0001);
    add_vertex(16'hFFFF, 16'h0000, 16'h0000);
    add_vertex(16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'd100, 16'hFF38, 16'd300);
    add_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
    add_vertex(16'h0003, 16'h0000, 16'hFFFE);
    wait_drained();

    // half gain on identity: ties round away from zero
    write_reg(REG_ROT_X, ROT_RESET);
    write_reg(REG_ROT_Y, ROT_RESET);
    write_reg(REG_ROT_Z, ROT_RESET);
    write_reg(REG_SCALE, 32'h0000_0800);
    write_reg(REG_OFFSET_X, 32'h0);
    write_reg(REG_OFFSET_Y, 32'h0);
    write_reg(REG_OFFSET_Z, 32'h0);
    settings_used++;
    add_vertex(16'h0001, 16'hFFFF, 16'h0003);
    add_vertex(16'hFFFD, 16'h0005, 16'hFFFB);
    add_vertex(16'h7FFF, 16'h8000, 16'hFFFF);
    wait_drained();

    // zero gain leaves only the offsets
    write_reg(REG_SCALE, 32'h0);
    write_reg(REG_OFFSET_X, 32'h0000_0005);
    write_reg(REG_OFFSET_Y, 32'h0000_FFF9);
    write_reg(REG_OFFSET_Z, 32'h0000_8001);
    settings_used++;
    add_vertex(16'h7FFF, 16'h8000, 16'h1234);
    add_vertex(16'h8000, 16'h7FFF, 16'hFFFF);
    wait_drained();

    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      mode = p % 4;
      in_gapless = (p % 5 == 2);
      out_gapless = (p % 5 == 2);
      write_reg(REG_ROT_X, trig_word(mode));
      write_reg(REG_ROT_Y, trig_word(mode));
      write_reg(REG_ROT_Z, trig_word(mode));
      case (mode)
        0: write_reg(REG_SCALE, {16'($urandom()), 16'($urandom_range(16'h0800, 16'h2000))});
        2: write_reg(REG_SCALE, {16'($urandom()), edge_coord()});
        default: write_reg(REG_SCALE, $urandom());
      endcase
      if (mode == 0) begin
        write_reg(REG_OFFSET_X, 32'($urandom_range(0, 255) - 128));
        write_reg(REG_OFFSET_Y, 32'($urandom_range(0, 255) - 128));
        write_reg(REG_OFFSET_Z, 32'($urandom_range(0, 255) - 128));
      end else if (mode == 2) begin
        write_reg(REG_OFFSET_X, {16'($urandom()), edge_coord()});
        write_reg(REG_OFFSET_Y, {16'($urandom()), edge_coord()});
        write_reg(REG_OFFSET_Z, {16'($urandom()), edge_coord()});
      end else begin
        write_reg(REG_OFFSET_X, $urandom());
        write_reg(REG_OFFSET_Y, $urandom());
        write_reg(REG_OFFSET_Z, $urandom());
      end
      if (mode == 1) write_reg(REG_UNUSED, $urandom());
      settings_used++;
      for (int i = 0; i < VERTS_PER_SETTING; i++)
        add_vertex(random_coord(), random_coord(), random_coord());
      wait_drained();
    end

    $display("%0d vertices transformed and checked under %0d register settings",
             results_checked, settings_used);
    $display("settings took in identity, out-of-unit trig words, zero and full gain, wrapping offsets");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
